@@ design/mvpd_pkg.sv @@
package mvpd_pkg;

    // field widths fixed by the sample and result formats
    localparam int AxisW = 16;
    localparam int MagW  = 32;

    // default window length and threshold after reset
    localparam int unsigned WindowDefault  = 5;
    localparam logic [MagW-1:0] ThresholdReset = 32'd12000;

    typedef logic signed [AxisW-1:0] axis_t;
    typedef logic [MagW-1:0]         mag_t;

    // baseline and flag after one tracker step
    typedef struct packed {
        mag_t baseline;
        logic present;
    } track_t;

endpackage

@@ design/mvpd_magsq.sv @@
module mvpd_magsq
(
    input  mvpd_pkg::axis_t axis_x,
    input  mvpd_pkg::axis_t axis_y,
    input  mvpd_pkg::axis_t axis_z,
    output mvpd_pkg::mag_t  magnitude_squared
);
    import mvpd_pkg::*;

    logic signed [MagW-1:0] sq_x;
    logic signed [MagW-1:0] sq_y;
    logic signed [MagW-1:0] sq_z;

    // each square is at most 2^30, so the sum of three stays inside 32 bits
    assign sq_x = MagW'(axis_x) * MagW'(axis_x);
    assign sq_y = MagW'(axis_y) * MagW'(axis_y);
    assign sq_z = MagW'(axis_z) * MagW'(axis_z);

    assign magnitude_squared = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);

endmodule

@@ design/mvpd_median.sv @@
module mvpd_median
#(
    parameter int unsigned WINDOW = mvpd_pkg::WindowDefault
)
(
    input  mvpd_pkg::mag_t [WINDOW-1:0] vals,
    output mvpd_pkg::mag_t              med
);
    import mvpd_pkg::*;

    localparam int unsigned Mid  = WINDOW / 2;
    localparam int unsigned CntW = $clog2(WINDOW);

    logic [CntW-1:0] rank [WINDOW];
    logic [WINDOW-1:0] sel;

    // rank of each entry among the window, ties broken by position
    always_comb
    begin
        for (int i = 0; i < WINDOW; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW; j++)
            begin
                if (j != i)
                begin
                    if ((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i)))
                    begin
                        rank[i] = rank[i] + 1'b1;
                    end
                end
            end
            sel[i] = (rank[i] == CntW'(Mid));
        end
    end

    // exactly one entry holds the middle rank
    always_comb
    begin
        med = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            med = med | (vals[i] & {MagW{sel[i]}});
        end
    end

endmodule

@@ design/mvpd_track.sv @@
module mvpd_track
#(
    parameter int unsigned WINDOW = mvpd_pkg::WindowDefault
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  mvpd_pkg::mag_t  magnitude_squared,
    input  mvpd_pkg::mag_t  threshold,
    output mvpd_pkg::track_t res
);
    import mvpd_pkg::*;

    mag_t [WINDOW-1:0] win_reg;
    mag_t [WINDOW-1:0] win_next;
    mag_t [WINDOW-1:0] win_shift;
    mag_t              base_reg;
    mag_t              base_next;
    logic              flag_reg;
    logic              flag_next;
    mag_t              med;
    mag_t              diff;

    // oldest entry at index 0, new value enters at the top
    assign win_shift = {magnitude_squared, win_reg[WINDOW-1:1]};

    mvpd_median #(.WINDOW(WINDOW)) u_median
    (
        .vals (win_shift),
        .med  (med)
    );

    always_comb
    begin
        if (flag_reg)
        begin
            win_next  = win_reg;
            base_next = base_reg;
        end
        else
        begin
            win_next  = win_shift;
            base_next = (med != '0) ? med : magnitude_squared;
        end
        // distance from baseline, band bounds count as inside
        if (magnitude_squared >= base_next)
        begin
            diff = magnitude_squared - base_next;
        end
        else
        begin
            diff = base_next - magnitude_squared;
        end
        flag_next = (diff > threshold);
    end

    assign res.baseline = base_next;
    assign res.present  = flag_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            base_reg <= '0;
            flag_reg <= 1'b0;
        end
        else if (step)
        begin
            win_reg  <= win_next;
            base_reg <= base_next;
            flag_reg <= flag_next;
        end
    end

endmodule

@@ design/magnetic_vehicle_presence_detector.sv @@
// vehicle presence detector on three-axis magnetometer samples. each sample
// transfer on the slave stream yields exactly one result transfer on the
// master stream carrying the squared magnitude x*x+y*y+z*z, the moving median
// baseline and the vehicle flag. while no vehicle is flagged the magnitude is
// pushed into a window of the last WINDOW values and the baseline follows its
// median (a zero median, seen while reset zeros remain, gives the new value);
// while a vehicle is flagged window and baseline are held. the flag is set
// when the magnitude lies outside baseline +/- threshold, bounds inside.
// one sample is taken every cycle while the result side keeps up; a stalled
// result holds every stage behind it. the sample lands in the input register
// at its transfer, its squares go into the magnitude register, then median,
// band test and state update go into the output register. the window,
// baseline and flag close their loop inside that last stage. the threshold
// port takes writes at any time (cfg_ready is always high) and should only be
// written with the block idle; reset value is 12000.
module magnetic_vehicle_presence_detector
#(
    parameter int unsigned WINDOW = mvpd_pkg::WindowDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    // sample stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // axis_x[15:0], axis_y[31:16], axis_z[47:32]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // magnitude_squared[31:0], baseline[63:32],
                                       // vehicle_present[64], zero[71:65]
    // threshold write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data       // band_threshold
);
    import mvpd_pkg::*;

    // threshold register
    mag_t   thr_reg;

    // input stage
    logic   in_vld_reg;
    axis_t  ax_reg;
    axis_t  ay_reg;
    axis_t  az_reg;

    // magnitude stage
    logic   mag_vld_reg;
    mag_t   mag_reg;
    mag_t   mag_comb;

    // output stage
    logic   out_vld_reg;
    mag_t   out_mag_reg;
    track_t out_trk_reg;
    track_t trk;

    // per-stage advance, each stage frees when its successor moves
    logic   rdy_out;
    logic   rdy_mag;
    logic   rdy_in;
    logic   step;

    assign rdy_out = !out_vld_reg || m_axis_tready;
    assign rdy_mag = !mag_vld_reg || rdy_out;
    assign rdy_in  = !in_vld_reg  || rdy_mag;
    assign step    = mag_vld_reg && rdy_out;

    assign s_axis_tready = rdy_in;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= ThresholdReset;
        end
        else if (cfg_valid)
        begin
            thr_reg <= cfg_data;
        end
    end

    // sample register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (rdy_in)
        begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_in && s_axis_tvalid)
        begin
            ax_reg <= s_axis_tdata[15:0];
            ay_reg <= s_axis_tdata[31:16];
            az_reg <= s_axis_tdata[47:32];
        end
    end

    mvpd_magsq u_magsq
    (
        .axis_x            (ax_reg),
        .axis_y            (ay_reg),
        .axis_z            (az_reg),
        .magnitude_squared (mag_comb)
    );

    // magnitude register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_vld_reg <= 1'b0;
        end
        else if (rdy_mag)
        begin
            mag_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_mag && in_vld_reg)
        begin
            mag_reg <= mag_comb;
        end
    end

    // window, baseline and flag move once per result
    mvpd_track #(.WINDOW(WINDOW)) u_track
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (step),
        .magnitude_squared (mag_reg),
        .threshold         (thr_reg),
        .res               (trk)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (rdy_out)
        begin
            out_vld_reg <= mag_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_mag_reg <= mag_reg;
            out_trk_reg <= trk;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {7'b0, out_trk_reg.present, out_trk_reg.baseline, out_mag_reg};

    // the sample side only stalls with every stage occupied
    a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_vld_reg && mag_vld_reg && out_vld_reg))
        else $error("sample side stalled with a free stage");

    // baseline is frozen while the last result flagged a vehicle
    a_baseline_held: assert property (@(posedge clk) disable iff (!rst_n)
        (step && out_vld_reg && out_trk_reg.present)
            |-> (trk.baseline == out_trk_reg.baseline))
        else $error("baseline moved while vehicle flagged");

    // a zero baseline only comes from a zero magnitude
    a_zero_baseline: assert property (@(posedge clk) disable iff (!rst_n)
        (step && trk.baseline == '0) |-> (mag_reg == '0))
        else $error("zero baseline with non-zero magnitude");

endmodule

@@ sim/tb_magnetic_vehicle_presence_detector.sv @@
module tb_magnetic_vehicle_presence_detector;

    import mvpd_pkg::*;

    localparam int WindowLen     = WindowDefault;
    // cycles with no transfer on any channel before the run is called hung
    localparam int WatchdogLimit = 4000;
    // wait after the last expected result has been checked, with margin
    localparam int SettleCycles  = 6;
    localparam int PhaseCount    = 8;
    localparam int PhaseItems    = 180;

    // one result transfer: squared magnitude, then baseline and flag
    typedef struct packed {
        mag_t   mag;
        track_t track;
    } presence_result_t;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RxFree,
        RxLight,
        RxHeavy,
        RxPeriodic
    } rx_mode_t;

    // mirror of the detector state, fed one accepted sample at a time
    class presence_scoreboard;
        mag_t             band_threshold;
        mag_t             window_vals[WindowLen];
        mag_t             baseline_hold;
        logic             present_flag;
        presence_result_t expected_results[$];
        int unsigned      failures;

        function new();
            band_threshold = ThresholdReset;
            foreach (window_vals[i])
            begin
                window_vals[i] = '0;
            end
            baseline_hold = '0;
            present_flag  = 1'b0;
            failures      = 0;
        endfunction

        function void set_threshold(mag_t value);
            band_threshold = value;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_sample(axis_t x, axis_t y, axis_t z);
            longint           sx;
            longint           sy;
            longint           sz;
            longint           m;
            longint           upper;
            longint           lower;
            mag_t             mag;
            mag_t             key;
            mag_t             sorted[WindowLen];
            int               j;
            presence_result_t res;
            sx  = x;
            sy  = y;
            sz  = z;
            mag = mag_t'(sx * sx + sy * sy + sz * sz);
            // window and baseline only move while no vehicle is flagged
            if (!present_flag)
            begin
                for (int i = 0; i < WindowLen - 1; i++)
                begin
                    window_vals[i] = window_vals[i + 1];
                end
                window_vals[WindowLen - 1] = mag;
                sorted = window_vals;
                for (int i = 1; i < WindowLen; i++)
                begin
                    key = sorted[i];
                    j   = i - 1;
                    while (j >= 0 && sorted[j] > key)
                    begin
                        sorted[j + 1] = sorted[j];
                        j--;
                    end
                    sorted[j + 1] = key;
                end
                // zero median while reset zeros remain: take the new value
                baseline_hold = (sorted[WindowLen / 2] != '0) ? sorted[WindowLen / 2] : mag;
            end
            // band test wide enough that the lower bound may go negative
            m             = longint'(mag);
            upper         = longint'(baseline_hold) + longint'(band_threshold);
            lower         = longint'(baseline_hold) - longint'(band_threshold);
            present_flag  = (m > upper) || (m < lower);
            res.mag            = mag;
            res.track.baseline = baseline_hold;
            res.track.present  = present_flag;
            expected_results.push_back(res);
        endfunction

        function void check_result(mag_t mag, mag_t baseline, logic present);
            presence_result_t exp_res;
            if (expected_results.size() == 0)
            begin
                $error("result transfer with no sample outstanding: mag %0d", mag);
                failures++;
                return;
            end
            exp_res = expected_results.pop_front();
            if (mag !== exp_res.mag)
            begin
                $error("magnitude_squared: expected %0d, actual %0d", exp_res.mag, mag);
                failures++;
            end
            if (baseline !== exp_res.track.baseline)
            begin
                $error("baseline: expected %0d, actual %0d", exp_res.track.baseline, baseline);
                failures++;
            end
            if (present !== exp_res.track.present)
            begin
                $error("vehicle_present: expected %0b, actual %0b",
                       exp_res.track.present, present);
                failures++;
            end
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data      = '0;

    presence_scoreboard sb;

    // sender burst state
    int       burst_left = 0;
    bit       gaps_on    = 1'b1;
    // receiver pattern state
    rx_mode_t rx_mode    = RxFree;
    int       rx_tick    = 0;
    int       stall_cycles = 0;

    magnetic_vehicle_presence_detector dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // axis_x[15:0], axis_y[31:16], axis_z[47:32]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // magnitude_squared[31:0], baseline[63:32],
                                         // vehicle_present[64]
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)        // band_threshold
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: pattern changes at random whenever rx_tick[5:0] wraps to zero, from always ready to heavy stalls
    always @(negedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (rx_tick[5:0] == 6'd0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        end
        case (rx_mode)
            RxFree:  m_axis_tready <= 1'b1;
            RxLight: m_axis_tready <= ($urandom_range(0, 3) != 0);
            RxHeavy: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (rx_tick[2:0] < 3'd5);
        endcase
    end

    // result monitor, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result(m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[64]);
        end
    end

    // watchdog: any transfer on any channel restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WatchdogLimit)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic axis_t clamp_axis(int v);
        if (v > 32767)
        begin
            return 16'sh7FFF;
        end
        if (v < -32768)
        begin
            return 16'sh8000;
        end
        return axis_t'(v);
    endfunction

    function automatic int jitter(int amp);
        return int'($urandom_range(0, 2 * amp)) - amp;
    endfunction

    // one sample transfer; bursts of random length with random gaps between while gaps_on is set
    task automatic send_sample(input axis_t x, input axis_t y, input axis_t z);
        int gap_len;
        if (burst_left == 0)
        begin
            if (gaps_on)
            begin
                gap_len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30)
                                                      : $urandom_range(1, 4);
                @(negedge clk) s_axis_tvalid <= 1'b0;
                repeat (gap_len - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_sample(x, y, z);
    endtask

    // threshold write, only once the detector has drained
    task automatic write_threshold(input mag_t value);
        @(negedge clk) s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.set_threshold(value);
        @(negedge clk) cfg_valid <= 1'b0;
        burst_left = 0;
    endtask

    // quiet road around a background field, vehicles passing now and then,
    // and some samples of pure noise
    task automatic run_phase(input int count);
        int bx;
        int by;
        int bz;
        int amp;
        int dx;
        int dy;
        int dz;
        int len;
        int r;
        int sent;
        bx   = int'($urandom_range(0, 1600)) - 800;
        by   = int'($urandom_range(0, 1600)) - 800;
        bz   = int'($urandom_range(0, 1600)) - 800;
        amp  = $urandom_range(0, 4);
        sent = 0;
        while (sent < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                send_sample(axis_t'($urandom), axis_t'($urandom), axis_t'($urandom));
                sent++;
            end
            else if (r < 30)
            begin
                // vehicle pass: a fixed disturbance for a few samples
                dx  = int'($urandom_range(0, 1200)) - 600;
                dy  = int'($urandom_range(0, 1200)) - 600;
                dz  = int'($urandom_range(0, 1200)) - 600;
                len = $urandom_range(2, 12);
                repeat (len)
                begin
                    send_sample(clamp_axis(bx + dx + jitter(amp)),
                                clamp_axis(by + dy + jitter(amp)),
                                clamp_axis(bz + dz + jitter(amp)));
                    sent++;
                end
            end
            else
            begin
                len = $urandom_range(1, 25);
                repeat (len)
                begin
                    send_sample(clamp_axis(bx + jitter(amp)), clamp_axis(by + jitter(amp)),
                                clamp_axis(bz + jitter(amp)));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        mag_t thr;
        sb = new();
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // empty window: zero median gives the new value as baseline
        send_sample(16'sd0, 16'sd0, 16'sd0);
        repeat (3) send_sample(16'sd100, 16'sd0, 16'sd0);

        // baseline 10000, band 7500..12500: both bounds inside, one above outside
        write_threshold(32'd2500);
        send_sample(16'sd100, 16'sd50, 16'sd0);
        send_sample(16'sd50, 16'sd50, 16'sd50);
        send_sample(16'sd100, 16'sd50, 16'sd1);
        // largest magnitudes while the baseline is held
        send_sample(16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_sample(-16'sd100, 16'sd0, 16'sd0);

        // zero threshold: only an exact match with the baseline is inside
        write_threshold(32'd0);
        send_sample(16'sd0, -16'sd100, 16'sd0);
        send_sample(16'sd0, 16'sd0, -16'sd100);
        send_sample(16'sd0, 16'sd0, 16'sd101);

        // widest threshold: lower bound far below zero, everything inside
        write_threshold(32'hFFFF_FFFF);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_sample(16'sd1, -16'sd1, 16'sd1);
        send_sample(16'sd0, 16'sd0, 16'sd0);

        for (int p = 0; p < PhaseCount; p++)
        begin
            case (p)
                0:       thr = ThresholdReset;
                1:       thr = '0;
                2:       thr = '1;
                3:       thr = 32'd1;
                4:       thr = $urandom;
                default: thr = $urandom_range(500, 60000);
            endcase
            write_threshold(thr);
            // every third phase runs with the sender never idling
            gaps_on = (p % 3 != 1);
            run_phase(PhaseItems);
        end

        @(negedge clk) s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
        if (sb.failures == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
